[rtl/cfd_pkg.sv]
package cfd_pkg;

  // Decoder phase within one message body
  typedef enum logic [2:0] {
    PH_LEN0  = 3'd0,
    PH_PAY0  = 3'd1,
    PH_LEN1  = 3'd2,
    PH_PAY1  = 3'd3,
    PH_AFTER = 3'd4,
    PH_ERROR = 3'd5
  } cfd_phase_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_LEN0_MISS = 3'd1,
    ST_INV0      = 3'd2,
    ST_LEN1_MISS = 3'd3,
    ST_INV1      = 3'd4,
    ST_TRAIL     = 3'd5,
    ST_BUSY      = 3'd6
  } cfd_status_e;

  // Configuration register indexes
  localparam logic REG_MAX_FIRST  = 1'b0;
  localparam logic REG_MAX_SECOND = 1'b1;

  localparam logic [15:0] MAX_LEN_RESET = 16'd255;

  typedef struct packed {
    logic        payload_valid;
    logic        field_index;
    logic [7:0]  payload_byte;
    logic        field_last;
    logic        done_res;
    cfd_status_e status;
  } cfd_res_t;

  typedef struct packed {
    cfd_phase_e  phase;
    cfd_status_e err;
  } cfd_state_t;

endpackage

[rtl/cfd_cfg.sv]
module cfd_cfg
  import cfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] max_first_o,
  output logic [15:0] max_second_o
);

  logic [15:0] max_first_q, max_first_d;
  logic [15:0] max_second_q, max_second_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    max_first_d  = max_first_q;
    max_second_d = max_second_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_MAX_FIRST:  max_first_d  = pwdata[15:0];
        REG_MAX_SECOND: max_second_d = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_first_q  <= MAX_LEN_RESET;
      max_second_q <= MAX_LEN_RESET;
    end else begin
      max_first_q  <= max_first_d;
      max_second_q <= max_second_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAX_FIRST:  prdata = {16'd0, max_first_q};
      REG_MAX_SECOND: prdata = {16'd0, max_second_q};
      default:        prdata = 32'd0;
    endcase
  end

  assign max_first_o  = max_first_q;
  assign max_second_o = max_second_q;

endmodule

[rtl/cfd_parse.sv]
module cfd_parse
  import cfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        cmd_i,
  input  logic [7:0]  byte_i,
  input  logic [15:0] max_first_i,
  input  logic [15:0] max_second_i,
  output cfd_res_t    res_o,
  output cfd_state_t  st_o
);

  cfd_phase_e  phase_q, phase_d;
  cfd_status_e err_q, err_d;
  logic [23:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [15:0] left_q, left_d;

  logic [31:0] len_full;
  logic [15:0] max_sel;
  logic        second;
  logic        len_bad;

  assign len_full = {acc_q, byte_i};
  assign second   = (phase_q == PH_LEN1) || (phase_q == PH_PAY1);
  assign max_sel  = second ? max_second_i : max_first_i;
  assign len_bad  = (len_full == 32'd0) || (len_full[31:16] != 16'd0) ||
                    (len_full[15:0] > max_sel);

  // Next state
  always_comb begin
    phase_d = phase_q;
    err_d   = err_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    left_d  = left_q;
    if (step_i) begin
      if (cmd_i) begin
        phase_d = PH_LEN0;
        err_d   = ST_OK;
        acc_d   = '0;
        cnt_d   = '0;
        left_d  = '0;
      end else begin
        unique case (phase_q)
          PH_LEN0, PH_LEN1: begin
            cnt_d = cnt_q + 2'd1;
            if (cnt_q == 2'd3) begin
              acc_d = '0;
              if (len_bad) begin
                phase_d = PH_ERROR;
                if (err_q == ST_OK) err_d = second ? ST_INV1 : ST_INV0;
              end else begin
                left_d  = len_full[15:0];
                phase_d = second ? PH_PAY1 : PH_PAY0;
              end
            end else begin
              acc_d = {acc_q[15:0], byte_i};
            end
          end
          PH_PAY0, PH_PAY1: begin
            if (left_q <= 16'd1) begin
              left_d  = '0;
              phase_d = second ? PH_AFTER : PH_LEN1;
            end else begin
              left_d = left_q - 16'd1;
            end
          end
          PH_AFTER: begin
            phase_d = PH_ERROR;
            if (err_q == ST_OK) err_d = ST_TRAIL;
          end
          default: ;
        endcase
      end
    end
  end

  // Result for the byte in the input register
  always_comb begin
    res_o        = '0;
    res_o.status = ST_BUSY;
    if (cmd_i) begin
      res_o.done_res = 1'b1;
      unique case (phase_q)
        PH_LEN0:  res_o.status = ST_LEN0_MISS;
        PH_PAY0:  res_o.status = ST_INV0;
        PH_LEN1:  res_o.status = ST_LEN1_MISS;
        PH_PAY1:  res_o.status = ST_INV1;
        PH_AFTER: res_o.status = ST_OK;
        default:  res_o.status = err_q;
      endcase
    end else if ((phase_q == PH_PAY0) || (phase_q == PH_PAY1)) begin
      res_o.payload_valid = 1'b1;
      res_o.field_index   = second;
      res_o.payload_byte  = byte_i;
      res_o.field_last    = (left_q <= 16'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEN0;
      err_q   <= ST_OK;
      acc_q   <= '0;
      cnt_q   <= '0;
      left_q  <= '0;
    end else begin
      phase_q <= phase_d;
      err_q   <= err_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
    end
  end

  assign st_o.phase = phase_q;
  assign st_o.err   = err_q;

endmodule

[rtl/credentials_field_decoder.sv]
// Path: a request accepted into the input register moves to the result register when it
//   steps (one input register, one result register) and then waits on the result stream.
// Throughput: one request per cycle while the result stream is not stalled; each body
//   byte or end marker yields exactly one result.
// Reset: rst_ni is asynchronous, active low; parser returns to expecting the first
//   length, both maximum-length registers return to 255, both stages empty.
module credentials_field_decoder
  import cfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] command (1 = end of body)
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [10:8] status, [15:11] zero
  output logic [2:0]  m_axis_tuser,   // [0] payload_valid, [1] field_index, [2] done_res
  output logic        m_axis_tlast,   // field_last
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] max_first, max_second;

  cfd_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .max_first_o  (max_first),
    .max_second_o (max_second)
  );

  // Input register: holds one request in front of the parser.
  logic       in_vld_q, in_vld_d;
  logic       in_cmd_q;
  logic [7:0] in_byte_q;

  // Result register.
  logic       out_vld_q, out_vld_d;
  cfd_res_t   out_res_q;

  logic       advance;   // result register can take a new value
  logic       step;      // parser consumes the held request this cycle
  cfd_res_t   res;
  cfd_state_t st;

  assign advance       = !out_vld_q || m_axis_tready;
  assign step          = in_vld_q && advance;
  // Take a new request when the input register is empty or the held one moves on this
  // cycle, so a waiting result alone does not stall the stream.
  assign s_axis_tready = !in_vld_q || advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_axis_tready) in_vld_d = s_axis_tvalid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // Payload: no reset needed, qualified by in_vld_q.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready) begin
      in_cmd_q  <= s_axis_tuser[0];
      in_byte_q <= s_axis_tdata;
    end
  end

  // Parser: combinational result for the held request; its state updates when the request steps.
  cfd_parse u_parse (
    .clk_i,
    .rst_ni,
    .step_i       (step),
    .cmd_i        (in_cmd_q),
    .byte_i       (in_byte_q),
    .max_first_i  (max_first),
    .max_second_i (max_second),
    .res_o        (res),
    .st_o         (st)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) out_vld_d = in_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  // Hold the result while the consumer stalls; load it when a step fires.
  always_ff @(posedge clk_i) begin
    if (step) out_res_q <= res;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, out_res_q.status, out_res_q.payload_byte};
  assign m_axis_tuser  = {out_res_q.done_res, out_res_q.field_index,
                          out_res_q.payload_valid};
  assign m_axis_tlast  = out_res_q.field_last;

  // A kept error always parks the parser in the error hold phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st.err != ST_OK) |-> (st.phase == PH_ERROR))
    else $error("error code kept outside error hold");

  // The error hold phase is only entered with an error recorded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st.phase == PH_ERROR) |-> (st.err != ST_OK))
    else $error("error hold without error code");

  // An end marker returns the parser to the first length with no error kept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_cmd_q) |=> (st.phase == PH_LEN0) && (st.err == ST_OK))
    else $error("body state not cleared after end marker");

  // Payload results carry busy status and never the end flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_res_q.payload_valid) |->
      (out_res_q.status == ST_BUSY) && !out_res_q.done_res)
    else $error("payload result with wrong status");

endmodule
